// ===== design/ppad_pkg.sv =====
`default_nettype none

package ppad_pkg;

    localparam int COORD_BITS = 16;
    localparam int ANGLE_BITS = 16;
    localparam int STAGES     = 16;

    localparam int GUARD_BITS  = 16;
    localparam int TURN_BITS   = 32;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int VEC_BITS    = COORD_BITS + GUARD_BITS + 3;
    localparam int LENGTH_BITS = COORD_BITS + 5;
    localparam int ROOT_BITS   = LENGTH_BITS;
    localparam int RAD_BITS    = 2 * ROOT_BITS;
    localparam int REM_BITS    = ROOT_BITS + 2;
    localparam int SQ_BITS     = 2 * COORD_BITS;

    localparam int DEPTH    = (STAGES > ROOT_BITS) ? STAGES : ROOT_BITS;
    localparam int IDX_BITS = $clog2(DEPTH);

    localparam int IN_FIELD_BITS  = 4 * COORD_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = ANGLE_BITS + LENGTH_BITS + 1;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int ANGLE_SHIFT = TURN_BITS - ANGLE_BITS;
    localparam logic [TURN_BITS-1:0] ROUND_ADD =
        (ANGLE_SHIFT == 0) ? '0 : TURN_BITS'(64'd1 << (ANGLE_SHIFT - 1));

    localparam logic [TURN_BITS-1:0] TURN_ZERO    = 32'h0000_0000;
    localparam logic [TURN_BITS-1:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [TURN_BITS-1:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [TURN_BITS-1:0] TURN_3QUART  = 32'hC000_0000;

    typedef struct packed {
        logic signed [VEC_BITS-1:0] x;
        logic signed [VEC_BITS-1:0] y;
        logic [TURN_BITS-1:0]       acc;
        logic                       exact;
        logic                       coincide;
    } cordic_t;

    typedef struct packed {
        logic [RAD_BITS-1:0]  rad;
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
    } sqrt_t;

    // atan(2^-k) in full turns over 2^32
    function automatic logic [TURN_BITS-1:0] ppad_arc(input logic [4:0] k);
        logic [TURN_BITS-1:0] a;
        case (k)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            5'd24:   a = 32'h00000029;
            5'd25:   a = 32'h00000014;
            5'd26:   a = 32'h0000000A;
            5'd27:   a = 32'h00000005;
            5'd28:   a = 32'h00000003;
            5'd29:   a = 32'h00000001;
            5'd30:   a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== design/ppad_front.sv =====
`default_nettype none

module ppad_front
    import ppad_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output logic                              out_valid,
    output cordic_t                           cord,
    output sqrt_t                             sq
);

    logic v1_reg, v2_reg, v3_reg;

    // stage 1: differences and magnitudes
    logic signed [DIFF_BITS-1:0] dx_next, dy_next, dx_reg, dy_reg;
    logic [COORD_BITS-1:0]       ax_next, ay_next, ax_reg, ay_reg;

    // stage 2: squares and CORDIC start vector
    logic [SQ_BITS-1:0] sqx_reg, sqy_reg;
    cordic_t            c2_next, c2_reg;

    // stage 3: radicand
    logic [RAD_BITS-1:0] rad_next, rad_reg;
    cordic_t             c3_reg;

    logic signed [VEC_BITS-1:0] xw, yw;

    always_comb
    begin
        dx_next = DIFF_BITS'(end_x) - DIFF_BITS'(start_x);
        dy_next = DIFF_BITS'(end_y) - DIFF_BITS'(start_y);
        ax_next = dx_next[DIFF_BITS-1] ? COORD_BITS'(-dx_next) : COORD_BITS'(dx_next);
        ay_next = dy_next[DIFF_BITS-1] ? COORD_BITS'(-dy_next) : COORD_BITS'(dy_next);
    end

    always_comb
    begin
        xw = VEC_BITS'(dx_reg) <<< GUARD_BITS;
        yw = VEC_BITS'(dy_reg) <<< GUARD_BITS;
        c2_next.coincide = (dx_reg == '0) && (dy_reg == '0);
        c2_next.exact    = (dx_reg == '0) || (dy_reg == '0);
        // up = -dy; left half plane is turned by a half turn first
        if (dx_reg[DIFF_BITS-1])
        begin
            c2_next.x   = -xw;
            c2_next.y   = yw;
            c2_next.acc = TURN_HALF;
        end
        else
        begin
            c2_next.x   = xw;
            c2_next.y   = -yw;
            c2_next.acc = TURN_ZERO;
        end
        if (c2_next.coincide)
            c2_next.acc = TURN_ZERO;
        else if (dy_reg == '0)
            c2_next.acc = dx_reg[DIFF_BITS-1] ? TURN_HALF : TURN_ZERO;
        else if (dx_reg == '0)
            c2_next.acc = dy_reg[DIFF_BITS-1] ? TURN_QUARTER : TURN_3QUART;
    end

    assign rad_next = RAD_BITS'(({1'b0, sqx_reg} + {1'b0, sqy_reg})) << 8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            ax_reg  <= ax_next;
            ay_reg  <= ay_next;
            sqx_reg <= ax_reg * ax_reg;
            sqy_reg <= ay_reg * ay_reg;
            c2_reg  <= c2_next;
            rad_reg <= rad_next;
            c3_reg  <= c2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign cord      = c3_reg;
    assign sq.rad    = rad_reg;
    assign sq.rem    = '0;
    assign sq.root   = '0;

endmodule

`default_nettype wire

// ===== design/ppad_cordic_cell.sv =====
`default_nettype none

module ppad_cordic_cell
    import ppad_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [IDX_BITS-1:0] stage_idx,
    input  wire cordic_t             din,
    output cordic_t                  dout
);

    cordic_t dout_reg, dout_next;

    logic signed [VEC_BITS-1:0] x_in, y_in, xs, ys;
    logic [TURN_BITS-1:0]       arc;
    logic                       active;

    assign x_in   = din.x;
    assign y_in   = din.y;
    assign xs     = x_in >>> stage_idx;
    assign ys     = y_in >>> stage_idx;
    assign arc    = ppad_arc(5'(stage_idx));
    // cells past the last iteration, and axis cases, only pass the vector on
    assign active = !din.exact && (int'(stage_idx) < STAGES);

    always_comb
    begin
        dout_next = din;
        if (active)
        begin
            if (!y_in[VEC_BITS-1])
            begin
                dout_next.x   = x_in + ys;
                dout_next.y   = y_in - xs;
                dout_next.acc = din.acc + arc;
            end
            else
            begin
                dout_next.x   = x_in - ys;
                dout_next.y   = y_in + xs;
                dout_next.acc = din.acc - arc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

// ===== design/ppad_sqrt_cell.sv =====
`default_nettype none

module ppad_sqrt_cell
    import ppad_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire logic active,
    input  wire sqrt_t din,
    output sqrt_t     dout
);

    sqrt_t dout_reg, dout_next;

    logic [REM_BITS+1:0] rem_w, trial;
    logic                take;

    // one root bit per cell: bring down two radicand bits, try root*4+1
    assign rem_w = {din.rem, din.rad[RAD_BITS-1 -: 2]};
    assign trial = (REM_BITS + 2)'({din.root, 2'b01});
    assign take  = (rem_w >= trial);

    always_comb
    begin
        dout_next = din;
        if (active)
        begin
            dout_next.rad  = din.rad << 2;
            dout_next.rem  = take ? REM_BITS'(rem_w - trial) : REM_BITS'(rem_w);
            dout_next.root = {din.root[ROOT_BITS-2:0], take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

// ===== design/point_pair_angle_and_distance_unit.sv =====
// Point pair to polar form: direction and distance from start to end point.
//
// Input stream (s_t*): one beat per point pair, coordinates signed, y down.
// Output stream (m_t*): one beat per input beat, same order. Direction is a
// fraction of a full turn (counterclockwise with y up), length carries four
// fraction bits, points_coincide flags equal points (direction and length 0).
//
// Throughput: one beat per cycle while not stalled. Three front stages
// (differences, squares, radicand), a chain of 21 cells that each do one
// square root bit, the first 16 also one CORDIC iteration, then the output
// register. The chain depth is the larger of the CORDIC iteration count and
// the number of root bits.
//
// Stall: the output register is backed by a one-beat skid register. While
// m_tready is low the chain keeps accepting until the skid fills; s_tready
// then drops and the whole chain holds. s_tready is a register output.
//
// Reset clears all valid bits; no beat is in flight afterwards.
`default_nettype none

module point_pair_angle_and_distance_unit
    import ppad_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // start_x, start_y, end_x, end_y
    input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // direction, length, points_coincide, zero pad
    output logic [OUT_DATA_BITS-1:0]      m_tdata
);

    logic en;
    logic front_valid;

    cordic_t cord [0:DEPTH];
    sqrt_t   sq   [0:DEPTH];
    logic    vld_reg [0:DEPTH-1];

    ppad_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .start_x   (s_tdata[COORD_BITS-1:0]),
        .start_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .end_x     (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .end_y     (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .out_valid (front_valid),
        .cord      (cord[0]),
        .sq        (sq[0])
    );

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        ppad_cordic_cell u_cordic (
            .clk       (clk),
            .en        (en),
            .stage_idx (IDX_BITS'(k)),
            .din       (cord[k]),
            .dout      (cord[k+1])
        );

        ppad_sqrt_cell u_sqrt (
            .clk    (clk),
            .en     (en),
            .active (k < ROOT_BITS),
            .din    (sq[k]),
            .dout   (sq[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= (k == 0) ? front_valid : vld_reg[(k == 0) ? 0 : k - 1];
        end
    end

    // finish: round the phase, round the root to nearest
    logic [TURN_BITS-1:0]      turn_sum;
    logic [ANGLE_BITS-1:0]     dir_fin;
    logic [LENGTH_BITS-1:0]    len_fin;
    logic                      coin_fin;
    logic [OUT_DATA_BITS-1:0]  data_fin;
    logic                      last_v;

    assign turn_sum = cord[DEPTH].acc + ROUND_ADD;
    assign coin_fin = cord[DEPTH].coincide;
    assign dir_fin  = coin_fin ? '0 : turn_sum[TURN_BITS-1 -: ANGLE_BITS];
    assign len_fin  = sq[DEPTH].root +
                      LENGTH_BITS'(sq[DEPTH].rem > REM_BITS'(sq[DEPTH].root));
    assign data_fin = OUT_DATA_BITS'({coin_fin, len_fin, dir_fin});
    assign last_v   = vld_reg[DEPTH-1];

    // output register with one-beat skid
    logic                     ov_reg, ov_next, sv_reg, sv_next;
    logic [OUT_DATA_BITS-1:0] od_reg, od_next, sd_reg, sd_next;

    always_comb
    begin
        ov_next = ov_reg;
        od_next = od_reg;
        sv_next = sv_reg;
        sd_next = sd_reg;
        if (sv_reg)
        begin
            if (m_tready)
            begin
                od_next = sd_reg;
                sv_next = 1'b0;
            end
        end
        else if (!ov_reg || m_tready)
        begin
            ov_next = last_v;
            od_next = data_fin;
        end
        else if (last_v)
        begin
            sv_next = 1'b1;
            sd_next = data_fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            sv_reg <= sv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
        sd_reg <= sd_next;
    end

    assign en       = !sv_reg;
    assign s_tready = en;
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

    logic [ANGLE_BITS-1:0]  m_dir;
    logic [LENGTH_BITS-1:0] m_len;
    logic                   m_coin;

    assign m_dir  = od_reg[ANGLE_BITS-1:0];
    assign m_len  = od_reg[ANGLE_BITS+LENGTH_BITS-1:ANGLE_BITS];
    assign m_coin = od_reg[ANGLE_BITS+LENGTH_BITS];

    a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        sv_reg |-> ov_reg)
        else $error("skid holds a beat while the output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sv_reg) |-> $past(ov_reg && !m_tready && last_v))
        else $error("skid filled without a stalled output");

    a_coincide_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_coin) |-> (m_dir == '0 && m_len == '0))
        else $error("coincident points with nonzero direction or length");

    a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_coin) |-> (m_len != '0))
        else $error("distinct points with zero length");

endmodule

`default_nettype wire
